// ----- src/mfap_pkg.sv -----
// Shared types and codes for the max-flow augmenting path core.
// No dependencies; imported by the core and its checker.
package mfap_pkg;

  localparam logic ACT_ADD_EDGE = 1'b0;
  localparam logic ACT_COMPUTE  = 1'b1;

  typedef enum logic [16:0] {
    S_CLEAR    = 17'h00001,
    S_IDLE     = 17'h00002,
    S_ADD_W1   = 17'h00004,
    S_ADD_RD   = 17'h00008,
    S_ADD_W2   = 17'h00010,
    S_BFS_INIT = 17'h00020,
    S_POP      = 17'h00040,
    S_POP_WAIT = 17'h00080,
    S_SCAN_RD  = 17'h00100,
    S_SCAN_EV  = 17'h00200,
    S_ADD_TOT  = 17'h00400,
    S_WALK     = 17'h00800,
    S_PAR_WAIT = 17'h01000,
    S_FW_RD    = 17'h02000,
    S_FW_WR    = 17'h04000,
    S_BW_RD    = 17'h08000,
    S_BW_WR    = 17'h10000
  } state_e;

endpackage

// ----- src/max_flow_augmenting_path_core.sv -----
// Edmonds-Karp maximum flow core: residual graph store, BFS sequencer, path walk.
// Depends on mfap_pkg.
//
//  channel | signals                                            | role
//  in      | in_valid_i/in_ready_o, action/from/to/capacity     | add edge or compute
//  out     | out_valid_o/out_ready_i, flow_total_o              | one total per compute
//
// After reset a clearing pass writes all VERTICES*VERTICES graph entries, one per
// cycle, and no item is accepted until it ends. Add and compute items share the
// single graph memory port for every read and write of the residual graph.
// The result waits in its register until taken.
module max_flow_augmenting_path_core #(
  parameter int VERTICES  = 64,
  parameter int CAP_BITS  = 16,
  parameter int FLOW_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [5:0]  from_vertex_i,
  input  logic [5:0]  to_vertex_i,
  input  logic [15:0] capacity_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] flow_total_o
);
  import mfap_pkg::*;

  localparam int VW = $clog2(VERTICES);
  localparam int CW = $clog2(VERTICES + 1);
  localparam int DEPTH = VERTICES * VERTICES;
  localparam int AW = $clog2(DEPTH);
  localparam int WW = FLOW_BITS + 1;
  localparam logic [15:0] CapMask = (CAP_BITS >= 16) ? 16'hFFFF : 16'((1 << CAP_BITS) - 1);
  localparam logic [FLOW_BITS-1:0] FlowMax = {FLOW_BITS{1'b1}};
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  state_e state_q, state_d;

  logic [WW-1:0] graph_mem [DEPTH];
  logic [WW-1:0] mem_rd_q;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [WW-1:0] mem_wdata;

  logic [VW-1:0] par_mem [VERTICES];
  logic [VW-1:0] par_rd_q;
  logic [VW-1:0] qv_mem [VERTICES];
  logic [FLOW_BITS-1:0] qb_mem [VERTICES];
  logic [VW-1:0] qv_rd_q;
  logic [FLOW_BITS-1:0] qb_rd_q;
  logic          q_we;
  logic [VW-1:0] q_waddr, q_wv;
  logic [FLOW_BITS-1:0] q_wb;

  logic [VERTICES-1:0] visited_q;
  logic [AW-1:0] clr_q;
  logic [VW-1:0] src_q, snk_q, cur_q, nx_q, prev_q;
  logic [CW-1:0] head_q, tail_q, steps_q;
  logic [FLOW_BITS-1:0] d_q, path_q, total_q, cap_q;

  logic in_range, in_acc;
  logic [15:0] cap_m;
  logic [FLOW_BITS-1:0] cap_c, rd_cap, nd;
  logic hit;

  function automatic logic [AW-1:0] eaddr(input logic [VW-1:0] a, input logic [VW-1:0] b);
    return AW'(a * VERTICES + b);
  endfunction

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_o;
  assign in_acc = in_valid_i && in_ready_o;
  assign in_range = (32'(from_vertex_i) < VERTICES) && (32'(to_vertex_i) < VERTICES);
  assign cap_m = capacity_value_i & CapMask;
  assign cap_c = (64'(cap_m) > 64'(FlowMax)) ? FlowMax : FLOW_BITS'(cap_m);
  assign rd_cap = mem_rd_q[FLOW_BITS-1:0];
  assign hit = mem_rd_q[FLOW_BITS] && !visited_q[nx_q] && (rd_cap != '0);
  assign nd = (rd_cap < d_q) ? rd_cap : d_q;
  assign flow_total_o = 24'(total_q);

  always_comb begin
    mem_we = 1'b0;
    mem_addr = '0;
    mem_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_q;
      end
      S_ADD_W1: begin
        mem_we = 1'b1;
        mem_addr = eaddr(src_q, snk_q);
        mem_wdata = {1'b1, cap_q};
      end
      S_ADD_RD: mem_addr = eaddr(snk_q, src_q);
      S_ADD_W2: begin
        mem_we = 1'b1;
        mem_addr = eaddr(snk_q, src_q);
        mem_wdata = {1'b1, rd_cap};
      end
      S_SCAN_RD: mem_addr = eaddr(cur_q, nx_q);
      S_FW_RD: mem_addr = eaddr(prev_q, cur_q);
      S_FW_WR: begin
        mem_we = 1'b1;
        mem_addr = eaddr(prev_q, cur_q);
        mem_wdata = {mem_rd_q[FLOW_BITS], rd_cap - path_q};
      end
      S_BW_RD: mem_addr = eaddr(cur_q, prev_q);
      S_BW_WR: begin
        mem_we = 1'b1;
        mem_addr = eaddr(cur_q, prev_q);
        mem_wdata = {mem_rd_q[FLOW_BITS],
                     (rd_cap > FlowMax - path_q) ? FlowMax : rd_cap + path_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      graph_mem[mem_addr] <= mem_wdata;
    end
    mem_rd_q <= graph_mem[mem_addr];
  end

  always_comb begin
    q_we = 1'b0;
    q_waddr = tail_q[VW-1:0];
    q_wv = nx_q;
    q_wb = nd;
    if (state_q == S_BFS_INIT) begin
      q_we = 1'b1;
      q_waddr = '0;
      q_wv = src_q;
      q_wb = FlowMax;
    end else if (state_q == S_SCAN_EV && hit && nx_q != snk_q && 32'(tail_q) < VERTICES) begin
      q_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qv_mem[q_waddr] <= q_wv;
      qb_mem[q_waddr] <= q_wb;
    end
    qv_rd_q <= qv_mem[head_q[VW-1:0]];
    qb_rd_q <= qb_mem[head_q[VW-1:0]];
    if (state_q == S_SCAN_EV && hit) begin
      par_mem[nx_q] <= cur_q;
    end
    par_rd_q <= par_mem[cur_q];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == LastAddr) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (action_i == ACT_ADD_EDGE) begin
            state_d = in_range ? S_ADD_W1 : S_IDLE;
          end else if (in_range && from_vertex_i != to_vertex_i) begin
            state_d = S_BFS_INIT;
          end
        end
      end
      S_ADD_W1: state_d = S_ADD_RD;
      S_ADD_RD: state_d = S_ADD_W2;
      S_ADD_W2: state_d = S_IDLE;
      S_BFS_INIT: state_d = S_POP;
      S_POP: state_d = (head_q == tail_q) ? S_IDLE : S_POP_WAIT;
      S_POP_WAIT: state_d = S_SCAN_RD;
      S_SCAN_RD: state_d = S_SCAN_EV;
      S_SCAN_EV: begin
        if (hit && nx_q == snk_q) begin
          state_d = S_ADD_TOT;
        end else if (nx_q == VW'(VERTICES - 1)) begin
          state_d = S_POP;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_ADD_TOT: state_d = S_WALK;
      S_WALK: state_d = (cur_q == src_q || 32'(steps_q) == VERTICES) ? S_BFS_INIT : S_PAR_WAIT;
      S_PAR_WAIT: state_d = S_FW_RD;
      S_FW_RD: state_d = S_FW_WR;
      S_FW_WR: state_d = S_BW_RD;
      S_BW_RD: state_d = S_BW_WR;
      S_BW_WR: state_d = S_WALK;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end else if (state_q == S_IDLE && in_acc && action_i == ACT_COMPUTE
                   && !(in_range && from_vertex_i != to_vertex_i)) begin
        out_valid_o <= 1'b1;
      end else if (state_q == S_POP && head_q == tail_q) begin
        out_valid_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          src_q <= VW'(from_vertex_i);
          snk_q <= VW'(to_vertex_i);
          cap_q <= cap_c;
          total_q <= '0;
        end
      end
      S_BFS_INIT: begin
        visited_q <= VERTICES'(1) << src_q;
        head_q <= '0;
        tail_q <= CW'(1);
      end
      S_POP: head_q <= head_q + CW'(1);
      S_POP_WAIT: begin
        cur_q <= qv_rd_q;
        d_q <= qb_rd_q;
        nx_q <= '0;
      end
      S_SCAN_EV: begin
        if (hit) begin
          visited_q[nx_q] <= 1'b1;
          path_q <= nd;
          if (nx_q != snk_q && 32'(tail_q) < VERTICES) begin
            tail_q <= tail_q + CW'(1);
          end
        end
        nx_q <= nx_q + VW'(1);
      end
      S_ADD_TOT: begin
        total_q <= (total_q > FlowMax - path_q) ? FlowMax : total_q + path_q;
        cur_q <= snk_q;
        steps_q <= '0;
      end
      S_PAR_WAIT: prev_q <= par_rd_q;
      S_BW_WR: begin
        cur_q <= prev_q;
        steps_q <= steps_q + CW'(1);
      end
      default: ;
    endcase
  end

endmodule

// ----- src/mfap_checker.sv -----
// Port-level checker for the max-flow augmenting path core, with its bind.
// Depends on mfap_pkg and max_flow_augmenting_path_core.
module mfap_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        action_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] flow_total_o
);
  import mfap_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while a result is pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(flow_total_o))
    else $error("result dropped or changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready right after an item");

  a_add_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_ADD_EDGE |=> !out_valid_o)
    else $error("result for an add item");

endmodule

bind max_flow_augmenting_path_core mfap_checker u_mfap_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .action_i(action_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .flow_total_o(flow_total_o)
);

// ----- tb/max_flow_augmenting_path_core_tb.sv -----
// Testbench for the Edmonds-Karp max-flow core: directed edge and flow items, then
// random graph episodes, checked against typed totals or an in-bench residual-graph predictor.
// Depends on mfap_pkg and max_flow_augmenting_path_core.
module max_flow_augmenting_path_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfap_pkg::*;

  localparam int NV = 64;
  localparam logic [23:0] FLOW_ONES = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 60000000;

  typedef struct {
    logic        act;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [15:0] cap;
    bit          typed;
    logic [23:0] flow;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = ACT_ADD_EDGE;
  logic [5:0]  from_vertex_i = '0;
  logic [5:0]  to_vertex_i = '0;
  logic [15:0] capacity_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [23:0] flow_total_o;

  logic [23:0] resid [NV*NV];
  bit          linked [NV*NV];
  logic [5:0]  parent [NV];
  logic [23:0] flow_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          n_adds = 0;
  int          n_flows = 0;
  int          n_results = 0;

  max_flow_augmenting_path_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL max_flow_augmenting_path_core");
      $finish;
    end
  end

  int stall_len = 0;
  always @(posedge clk_i) begin
    if (stall_len > 0) begin
      stall_len <= stall_len - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_len <= $urandom_range(1, 12);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (flow_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %0d", $realtime, flow_total_o);
      end else begin
        if (flow_total_o !== flow_q[0]) begin
          errors++;
          $display("%0t: flow_total expected %0d actual %0d", $realtime, flow_q[0],
                   flow_total_o);
        end
        void'(flow_q.pop_front());
      end
    end
  end

  function automatic logic [23:0] find_path(int s, int t);
    int          fifo_v [NV];
    logic [23:0] fifo_b [NV];
    bit          seen [NV];
    int          head;
    int          tail;
    int          cur;
    int          e;
    logic [23:0] b;
    logic [23:0] nb;
    head = 0;
    tail = 1;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[s] = 1'b1;
    fifo_v[0] = s;
    fifo_b[0] = FLOW_ONES;
    while (head < tail) begin
      cur = fifo_v[head];
      b = fifo_b[head];
      head++;
      for (int nx = 0; nx < NV; nx++) begin
        e = cur * NV + nx;
        if (linked[e] && !seen[nx] && resid[e] != 0) begin
          nb = (resid[e] < b) ? resid[e] : b;
          seen[nx] = 1'b1;
          parent[nx] = 6'(cur);
          if (nx == t) return nb;
          if (tail < NV) begin
            fifo_v[tail] = nx;
            fifo_b[tail] = nb;
            tail++;
          end
        end
      end
    end
    return '0;
  endfunction

  function automatic logic [23:0] peak_flow(int s, int t);
    logic [23:0] total;
    logic [23:0] d;
    int          cur;
    int          prev;
    int          steps;
    total = '0;
    if (s == t) return '0;
    forever begin
      d = find_path(s, t);
      if (d == 0) break;
      total = (total > FLOW_ONES - d) ? FLOW_ONES : total + d;
      cur = t;
      steps = 0;
      while (cur != s && steps < NV) begin
        prev = parent[cur];
        resid[prev * NV + cur] -= d;
        if (resid[cur * NV + prev] > FLOW_ONES - d) resid[cur * NV + prev] = FLOW_ONES;
        else resid[cur * NV + prev] += d;
        cur = prev;
        steps++;
      end
    end
    return total;
  endfunction

  task automatic send_item(row_t r);
    logic [23:0] f;
    in_valid_i <= 1'b1;
    action_i <= r.act;
    from_vertex_i <= r.src;
    to_vertex_i <= r.dst;
    capacity_value_i <= r.cap;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    if (r.act == ACT_ADD_EDGE) begin
      n_adds++;
      resid[r.src * NV + r.dst] = {8'h00, r.cap};
      linked[r.src * NV + r.dst] = 1'b1;
      linked[r.dst * NV + r.src] = 1'b1;
    end else begin
      n_flows++;
      f = peak_flow(r.src, r.dst);
      flow_q.push_back(r.typed ? r.flow : f);
    end
  endtask

  int burst_left = 0;
  task automatic issue(row_t r);
    send_item(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  function automatic row_t mk(logic act, int s, int d, int c, bit typed = 0, int f = 0);
    row_t r;
    r.act = act;
    r.src = 6'(s);
    r.dst = 6'(d);
    r.cap = 16'(c);
    r.typed = typed;
    r.flow = 24'(f);
    return r;
  endfunction

  row_t directed [$];
  row_t r;
  int   base;
  int   span;
  int   sent;

  initial begin
    foreach (resid[i]) begin
      resid[i] = '0;
      linked[i] = 1'b0;
    end
    directed = '{
      mk(ACT_COMPUTE, 0, 1, 16'hFFFF, 1, 0),
      mk(ACT_COMPUTE, 63, 63, 0, 1, 0),
      mk(ACT_ADD_EDGE, 0, 1, 16'hFFFF),
      mk(ACT_ADD_EDGE, 1, 63, 16'hFFFF),
      mk(ACT_COMPUTE, 0, 63, 0, 1, 65535),
      mk(ACT_COMPUTE, 0, 63, 0, 1, 0),
      mk(ACT_COMPUTE, 63, 0, 0),
      mk(ACT_ADD_EDGE, 2, 2, 100),
      mk(ACT_COMPUTE, 2, 2, 0, 1, 0),
      mk(ACT_ADD_EDGE, 2, 3, 0),
      mk(ACT_COMPUTE, 2, 3, 16'hFFFF, 1, 0),
      mk(ACT_ADD_EDGE, 10, 11, 1),
      mk(ACT_ADD_EDGE, 11, 12, 16'hAAAA),
      mk(ACT_ADD_EDGE, 10, 12, 16'h5555),
      mk(ACT_COMPUTE, 10, 12, 0),
      mk(ACT_ADD_EDGE, 62, 61, 16'h8000),
      mk(ACT_COMPUTE, 62, 61, 0, 1, 32768),
      mk(ACT_COMPUTE, 61, 62, 0)
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) issue(directed[i]);

    sent = 0;
    while (sent < 800) begin
      base = $urandom_range(0, 56);
      span = $urandom_range(2, 8);
      repeat ($urandom_range(2, 10)) begin
        r = mk(ACT_ADD_EDGE, base + $urandom_range(0, span - 1),
               base + $urandom_range(0, span - 1),
               ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40));
        issue(r);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        issue(mk(1'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 65535)));
        sent++;
      end
      issue(mk(ACT_COMPUTE, base + $urandom_range(0, span - 1),
               base + $urandom_range(0, span - 1), $urandom_range(0, 65535)));
      sent++;
    end
    in_valid_i <= 1'b0;

    while (flow_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d edge writes and %0d flow queries; %0d results checked.",
             n_adds, n_flows, n_results);
    if (errors == 0) begin
      $display("PASS max_flow_augmenting_path_core");
    end else begin
      $display("FAIL max_flow_augmenting_path_core");
    end
    $finish;
  end
endmodule
